/* src/evg_pkg.sv */
// Shared types and constants for the exponential variate generator.
`default_nettype none

package evg_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SAMPLE_W = 40;
  localparam int unsigned J_W      = 6;
  localparam int unsigned K_W      = 4;
  localparam int unsigned W_W      = 38;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned NUM_Q    = 9;

  localparam logic [WORD_W-1:0] LN2_Q32    = 32'd2977044472;
  localparam logic [WORD_W-1:0] MEAN_RESET = 32'h0001_0000;
  localparam logic [PROD_W-1:0] ROUND_HALF = 64'h0000_0000_8000_0000;
  localparam logic [K_W-1:0]    K_BASE     = 4'd2;

  localparam logic [WORD_W-1:0] Q_LIMIT [NUM_Q] = '{
    32'd4008809463, 32'd4247197795, 32'd4288507345, 32'd4294234064,
    32'd4294895641, 32'd4294961151, 32'd4294966827, 32'd4294967264,
    32'd4294967294
  };

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_COUNT = 8'b0000_0010,
    ST_VMUL  = 8'b0000_0100,
    ST_JMUL  = 8'b0000_1000,
    ST_WSUM  = 8'b0001_0000,
    ST_LMUL  = 8'b0010_0000,
    ST_HMUL  = 8'b0100_0000,
    ST_SUM   = 8'b1000_0000
  } evg_state_t;

  // Number of words whose minimum is taken for fraction u.
  function automatic logic [K_W-1:0] q_count(input logic [WORD_W-1:0] u);
    logic [K_W-1:0] k;
    logic           stop;
    k    = K_BASE;
    stop = 1'b0;
    for (int i = 0; i < NUM_Q; i++) begin
      if (!stop && (u >= Q_LIMIT[i])) begin
        k = k + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* src/evg_if.sv */
// Valid/ready channel interfaces for random words, samples and the mean register.
`default_nettype none

interface evg_word_if import evg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] uniform_word;
  modport source (output valid, output uniform_word, input ready);
  modport sink (input valid, input uniform_word, output ready);
endinterface

interface evg_sample_if import evg_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface evg_cfg_if import evg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] mean_value;
  modport source (output valid, output mean_value, input ready);
  modport sink (input valid, input mean_value, output ready);
endinterface

`default_nettype wire

/* src/exponential_variate_generator_top.sv */
// Exponential variate generator top level: sequencer around one shared 32x32 multiplier.
//
//   channel   dir  payload              meaning
//   cfg       in   mean_value [31:0]    distribution mean, Q16.16
//   words     in   uniform_word [31:0]  uniform random word
//   samples   out  sample [39:0]        exponential variate, Q24.16
//
// A starting word with j leading ones is scanned one bit of the leading-ones scan per
// cycle, then passes through the multiply/round/add states JMUL, WSUM, LMUL, HMUL and SUM
// for a direct sample. A collecting word is taken in idle; the last one goes on through
// VMUL and the same states for v*ln2, j*ln2 and the scale by the mean, all through the one multiplier.
// Reset is synchronous; it restores the mean to 1.0 and empties the output register.
// The final add stalls while an earlier sample is still waiting on samples.
`default_nettype none

module exponential_variate_generator_top import evg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  evg_cfg_if.sink      cfg,
  evg_word_if.sink     words,
  evg_sample_if.source samples
);

  evg_state_t          state;
  logic [WORD_W-1:0]   mean_value;
  logic                collecting;
  logic [J_W-1:0]      leading_ones;
  logic [K_W-1:0]      words_left;
  logic [WORD_W-1:0]   running_min;
  logic [WORD_W-1:0]   shreg;
  logic [WORD_W-1:0]   frac;
  logic                via_min;
  logic [PROD_W-1:0]   prod;
  logic [W_W-1:0]      wsum;
  logic [WORD_W-1:0]   lo_rnd;
  logic [SAMPLE_W-1:0] sample;
  logic                out_valid;

  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [WORD_W-1:0]   u;
  logic [WORD_W-1:0]   min_next;
  logic [PROD_W-1:0]   prod_biased;
  logic [WORD_W-1:0]   prod_rnd;
  logic                load_out;

  assign u           = {shreg[WORD_W-2:0], 1'b0};
  assign min_next    = (words.uniform_word < running_min) ? words.uniform_word : running_min;
  assign prod_biased = prod + ROUND_HALF;
  assign prod_rnd    = prod_biased[PROD_W-1:WORD_W];
  assign mul_p       = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign load_out    = (state == ST_SUM) && (!out_valid || samples.ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_VMUL: begin
        mul_a = running_min;
        mul_b = LN2_Q32;
      end
      ST_JMUL: begin
        mul_a = {{(WORD_W-J_W){1'b0}}, leading_ones};
        mul_b = LN2_Q32;
      end
      ST_LMUL: begin
        mul_a = mean_value;
        mul_b = wsum[WORD_W-1:0];
      end
      ST_HMUL: begin
        mul_a = mean_value;
        mul_b = {{(WORD_W-(W_W-WORD_W)){1'b0}}, wsum[W_W-1:WORD_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cfg.ready      = 1'b1;
  assign words.ready    = (state == ST_IDLE);
  assign samples.valid  = out_valid;
  assign samples.sample = sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mean_value   <= MEAN_RESET;
      collecting   <= 1'b0;
      leading_ones <= '0;
      words_left   <= '0;
      running_min  <= '1;
      via_min      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        mean_value <= cfg.mean_value;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && samples.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (words.valid) begin
            if (collecting) begin
              running_min <= min_next;
              if (words_left > 4'd1) begin
                words_left <= words_left - 4'd1;
              end else begin
                words_left <= '0;
                collecting <= 1'b0;
                via_min    <= 1'b1;
                state      <= ST_VMUL;
              end
            end else begin
              shreg        <= (words.uniform_word == '0) ? 32'd1 : words.uniform_word;
              leading_ones <= '0;
              state        <= ST_COUNT;
            end
          end
        end
        ST_COUNT: begin
          if (shreg[WORD_W-1]) begin
            shreg        <= u;
            leading_ones <= leading_ones + 6'd1;
          end else if (u < LN2_Q32) begin
            frac    <= u;
            via_min <= 1'b0;
            state   <= ST_JMUL;
          end else begin
            collecting  <= 1'b1;
            words_left  <= q_count(u);
            running_min <= '1;
            state       <= ST_IDLE;
          end
        end
        ST_VMUL: begin
          prod  <= mul_p;
          state <= ST_JMUL;
        end
        ST_JMUL: begin
          if (via_min) begin
            frac <= prod_rnd;
          end
          prod  <= mul_p;
          state <= ST_WSUM;
        end
        ST_WSUM: begin
          wsum        <= prod[W_W-1:0] + {{(W_W-WORD_W){1'b0}}, frac};
          running_min <= '1;
          state       <= ST_LMUL;
        end
        ST_LMUL: begin
          prod  <= mul_p;
          state <= ST_HMUL;
        end
        ST_HMUL: begin
          lo_rnd <= prod_rnd;
          prod   <= mul_p;
          state  <= ST_SUM;
        end
        ST_SUM: begin
          if (load_out) begin
            sample <= prod[SAMPLE_W-1:0] + {{(SAMPLE_W-WORD_W){1'b0}}, lo_rnd};
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_collect_idle: assert property (@(posedge clk) disable iff (rst)
    collecting |-> (state == ST_IDLE) && (words_left != '0))
    else $error("collection active outside idle or with no words left");

  a_onehot_state: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_sum_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) && (!out_valid || samples.ready) |=> out_valid && (state == ST_IDLE))
    else $error("final add did not load the output register");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    words.valid && words.ready && collecting && (words_left == 4'd1) |=> (state == ST_VMUL))
    else $error("last collected word did not start the minimum scaling");
`endif

endmodule

`default_nettype wire

/* verif/evg_sample_checker.sv */
`timescale 1ns / 1ps
// Watches the mean, random word and sample channels, predicts each sample and compares.

module evg_sample_checker import evg_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  evg_cfg_if          cfg,
  evg_word_if         words,
  evg_sample_if       samples,
  output int unsigned fail_count,
  output int unsigned pending,
  output logic        collecting
);

  localparam int unsigned MAX_REPORTS = 10;

  logic [WORD_W-1:0]   mean_q;
  logic [J_W-1:0]      lead_ones;
  logic [K_W-1:0]      words_left;
  logic [WORD_W-1:0]   run_min;
  logic [SAMPLE_W-1:0] expected_samples [$];
  logic [SAMPLE_W-1:0] want;
  int unsigned         reports;

  function automatic logic [SAMPLE_W-1:0] scale_by_mean(input logic [WORD_W-1:0] m,
                                                        input logic [W_W-1:0]    w);
    logic [PROD_W-1:0] hi;
    logic [PROD_W-1:0] lo;
    hi = PROD_W'(m) * PROD_W'(w[W_W-1:WORD_W]);
    lo = (PROD_W'(m) * PROD_W'(w[WORD_W-1:0]) + ROUND_HALF) >> WORD_W;
    return SAMPLE_W'(hi + lo);
  endfunction

  task automatic take_word(input logic [WORD_W-1:0] word_in);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] u;
    logic [W_W-1:0]    w;
    logic [K_W-1:0]    k;
    int                j;
    if (collecting) begin
      if (word_in < run_min) begin
        run_min = word_in;
      end
      if (words_left > 1) begin
        words_left = words_left - 1'b1;
      end else begin
        w = W_W'(lead_ones) * W_W'(LN2_Q32) +
            W_W'((PROD_W'(run_min) * PROD_W'(LN2_Q32) + ROUND_HALF) >> WORD_W);
        expected_samples.push_back(scale_by_mean(mean_q, w));
        collecting = 1'b0;
        words_left = '0;
        run_min    = '1;
      end
    end else begin
      word = (word_in == '0) ? WORD_W'(1) : word_in;
      j = 0;
      while (j < WORD_W && word[WORD_W-1-j]) begin
        j++;
      end
      u = (j >= WORD_W - 1) ? '0 : word << (j + 1);
      if (u < LN2_Q32) begin
        w = W_W'(j) * W_W'(LN2_Q32) + W_W'(u);
        expected_samples.push_back(scale_by_mean(mean_q, w));
      end else begin
        k = 4'd2;
        for (int i = 0; i < NUM_Q; i++) begin
          if (u >= Q_LIMIT[i]) begin
            k = k + 1'b1;
          end else begin
            break;
          end
        end
        collecting = 1'b1;
        lead_ones  = J_W'(j);
        words_left = k;
        run_min    = '1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mean_q     = MEAN_RESET;
      collecting = 1'b0;
      lead_ones  = '0;
      words_left = '0;
      run_min    = '1;
      expected_samples.delete();
      fail_count = 0;
      reports    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        mean_q = cfg.mean_value;
      end
      if (samples.valid && samples.ready) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("unexpected sample %h", samples.sample);
          end
        end else begin
          want = expected_samples.pop_front();
          if (samples.sample !== want) begin
            fail_count++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("sample mismatch: expected %h, actual %h", want, samples.sample);
            end
          end
        end
      end
      if (words.valid && words.ready) begin
        take_word(words.uniform_word);
      end
    end
    pending = expected_samples.size();
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the exponential variate generator.

module tb_top;
  import evg_pkg::*;

  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 304;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic [WORD_W-1:0] DIRECTED_WORDS [24] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
    32'h8000_0000, 32'h7FFF_FFFF,
    32'hFFFF_FFFF, 32'h0000_0000, 32'hDEAD_BEEF, 32'h0000_0001,
    32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
    32'h6000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h58B9_0BFB, 32'h58B9_0BFC, 32'h0000_0000, 32'h0000_0003
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        hold = 1'b0;
  logic        hold_go = 1'b0;
  int unsigned src_idle = 36;
  int unsigned snk_idle = 69;
  int unsigned fails;
  int unsigned pending;
  logic        collecting;

  evg_cfg_if    cfg_ch ();
  evg_word_if   words_ch ();
  evg_sample_if samples_ch ();

  exponential_variate_generator_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .words   (words_ch),
    .samples (samples_ch)
  );

  evg_sample_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .words      (words_ch),
    .samples    (samples_ch),
    .fail_count (fails),
    .pending    (pending),
    .collecting (collecting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    samples_ch.ready <= !hold && ($urandom_range(99) >= snk_idle);
  end

  initial begin
    wait (hold_go);
    @(negedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] tail;
    int unsigned       j;
    int unsigned       n;
    int unsigned       pick;
    pick = $urandom_range(9);
    if (pick <= 4) begin
      return $urandom;
    end else if (pick == 9) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    if (pick <= 6) begin
      j    = $urandom_range(32);
      tail = $urandom;
    end else begin
      j    = $urandom_range(3);
      n    = $urandom_range(1, 32);
      tail = ~(32'hFFFF_FFFF >> n) | ($urandom >> n);
    end
    return ~(32'hFFFF_FFFF >> j) | (tail >> (j + 1));
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < src_idle) begin
      words_ch.valid <= 1'b0;
      @(negedge clk);
    end
    words_ch.valid        <= 1'b1;
    words_ch.uniform_word <= w;
    @(posedge clk);
    while (!words_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mean(input logic [WORD_W-1:0] m);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.mean_value <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // finish any open collection, then drain
  task automatic settle();
    while (collecting) send_word(random_word());
    words_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [WORD_W-1:0] mean_plan [PHASES];
    words_ch.valid        = 1'b0;
    words_ch.uniform_word = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.mean_value     = '0;
    mean_plan = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0000_0000,
                  32'h0002_8000, 32'h0};
    mean_plan[2] = $urandom;
    mean_plan[5] = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED_WORDS[i]) begin
      send_word(DIRECTED_WORDS[i]);
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          src_idle = 36;
          snk_idle = 69;
        end
        1: begin
          src_idle = 69;
          snk_idle = 36;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      write_mean(mean_plan[p]);
      if (p == PHASES - 1) begin
        hold_go <= 1'b1;
      end
      repeat (PHASE_ITEMS) send_word(random_word());
      settle();
    end

    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
